/* rtl/itt_pkg.sv */
package itt_pkg;

  // Field and storage widths
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int POS_W         = 6;
  localparam int ORD_W         = 2;
  localparam int RESULT_CAP    = 64;
  localparam int MAX_NODES_DEF = 64;

  // Walk stack: one frame per tree level, node index plus visit phase
  localparam int STACK_DEPTH   = 7;
  localparam int STK_W         = $clog2(STACK_DEPTH + 1);

  // Configuration port
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam logic [PADDR_W-3:0] REG_NODE_COUNT = 1'b0;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_WALK = 1'b1
  } kind_e;

  typedef enum logic [ORD_W-1:0] {
    ORD_IN   = 2'd0,
    ORD_PRE  = 2'd1,
    ORD_POST = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    PH_PRE  = 2'd0,
    PH_MID  = 2'd1,
    PH_POST = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    phase_e           ph;
  } frame_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic emit;
    logic advance;
    logic push_left;
    logic push_right;
    logic pop;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic   slot_free;
    phase_e top_ph;
    logic   left_ok;
    logic   right_ok;
    logic   last_frame;
    order_e order;
  } sts_t;

endpackage

/* rtl/itt_channels.sv */
interface itt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [itt_pkg::DATA_W-1:0]   load_value;
  logic        [itt_pkg::ORD_W-1:0]    walk_order;

  modport source (output valid, kind, load_value, walk_order, input ready);
  modport sink   (input valid, kind, load_value, walk_order, output ready);
endinterface

interface itt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [itt_pkg::DATA_W-1:0]   node_value;
  logic        [itt_pkg::POS_W-1:0]    sequence_position;
  logic                                last_in_walk;

  modport source (output valid, node_value, sequence_position, last_in_walk, input ready);
  modport sink   (input valid, node_value, sequence_position, last_in_walk, output ready);
endinterface

/* rtl/itt_ram.sv */
module itt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/itt_ctrl.sv */
module itt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_kind_i,
  input  logic [itt_pkg::ORD_W-1:0]     in_order_i,
  input  itt_pkg::sts_t                 sts_i,
  output itt_pkg::cmd_t                 cmd_o
);

  itt_pkg::state_e state_q, state_d;
  logic            order_ok;

  // Only the three defined orders start a walk
  assign order_ok = (in_order_i == itt_pkg::ORD_IN)  ||
                    (in_order_i == itt_pkg::ORD_PRE) ||
                    (in_order_i == itt_pkg::ORD_POST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      itt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == itt_pkg::KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            if (order_ok) begin
              state_d = itt_pkg::ST_WALK;
            end
          end
        end
      end
      itt_pkg::ST_WALK: begin
        // One visit step on the top frame when the output side can take a node
        if (sts_i.slot_free) begin
          case (sts_i.top_ph)
            itt_pkg::PH_PRE: begin
              cmd_o.emit      = (sts_i.order == itt_pkg::ORD_PRE);
              cmd_o.advance   = 1'b1;
              cmd_o.push_left = sts_i.left_ok;
            end
            itt_pkg::PH_MID: begin
              cmd_o.emit       = (sts_i.order == itt_pkg::ORD_IN);
              cmd_o.advance    = 1'b1;
              cmd_o.push_right = sts_i.right_ok;
            end
            itt_pkg::PH_POST: begin
              cmd_o.emit = (sts_i.order == itt_pkg::ORD_POST);
              cmd_o.pop  = 1'b1;
              if (sts_i.last_frame) begin
                state_d = itt_pkg::ST_IDLE;
              end
            end
            default: begin
              state_d = itt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = itt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/itt_dp.sv */
module itt_dp #(
  parameter int MAX_NODES = itt_pkg::MAX_NODES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  itt_pkg::cmd_t                      cmd_i,
  input  logic signed [itt_pkg::DATA_W-1:0]  load_value_i,
  input  logic        [itt_pkg::ORD_W-1:0]   walk_order_i,
  input  logic        [itt_pkg::CNT_W-1:0]   node_count_i,
  output itt_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [itt_pkg::DATA_W-1:0]  node_value_o,
  output logic        [itt_pkg::POS_W-1:0]   sequence_position_o,
  output logic                               last_in_walk_o
);

  localparam int AW      = $clog2(MAX_NODES);
  localparam int CAP_INT = (MAX_NODES < itt_pkg::RESULT_CAP) ? MAX_NODES
                                                             : itt_pkg::RESULT_CAP;
  localparam logic [itt_pkg::CNT_W-1:0] CAP = itt_pkg::CNT_W'(CAP_INT);
  localparam logic [itt_pkg::STK_W-1:0] STK_MAX = itt_pkg::STK_W'(itt_pkg::STACK_DEPTH);

  logic [itt_pkg::CNT_W-1:0]  count_eff;
  logic [itt_pkg::CNT_W-1:0]  ptr_q, ptr_d;
  logic [itt_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [itt_pkg::CNT_W-1:0]  total_q, total_d;
  logic [itt_pkg::STK_W-1:0]  depth_q, depth_d;
  logic [itt_pkg::STK_W-1:0]  top_ptr;
  itt_pkg::order_e            order_q, order_d;
  itt_pkg::frame_t            stk_q [itt_pkg::STACK_DEPTH];
  itt_pkg::frame_t            top;
  itt_pkg::phase_e            ph_next;
  logic [itt_pkg::CNT_W:0]    left_idx;
  logic [itt_pkg::CNT_W:0]    right_idx;
  logic                       pend_q, pend_d;
  logic [itt_pkg::POS_W-1:0]  pend_pos_q;
  logic                       pend_last_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [itt_pkg::DATA_W-1:0] out_value_q;
  logic [itt_pkg::POS_W-1:0]  out_pos_q;
  logic                       out_last_q;
  logic                       load_we;
  logic [itt_pkg::DATA_W-1:0] rdata;

  // Clamp the node count to at least one and at most the store and result cap
  always_comb begin
    count_eff = (node_count_i == '0) ? itt_pkg::CNT_W'(1) : node_count_i;
    if (count_eff > CAP) begin
      count_eff = CAP;
    end
  end

  // Top of stack and its children
  assign top_ptr   = depth_q - 1'b1;
  assign top       = stk_q[top_ptr];
  assign left_idx  = {1'b0, top.idx, 1'b1};
  assign right_idx = {1'b0, top.idx, 1'b0} + (itt_pkg::CNT_W + 1)'(2);

  always_comb begin
    case (top.ph)
      itt_pkg::PH_PRE: ph_next = itt_pkg::PH_MID;
      default:         ph_next = itt_pkg::PH_POST;
    endcase
  end

  assign load_we = cmd_i.load && (ptr_q < count_eff);

  // Tree store
  itt_ram #(
    .WIDTH (itt_pkg::DATA_W),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(ptr_q)),
    .wdata_i (load_value_i),
    .re_i    (cmd_i.emit),
    .raddr_i (AW'(top.idx)),
    .rdata_o (rdata)
  );

  // Control next state
  always_comb begin
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    order_d     = order_q;
    depth_d     = depth_q;
    pend_d      = cmd_i.emit;
    out_valid_d = out_valid_q;
    if (load_we) begin
      ptr_d = ptr_q + 1'b1;
    end
    if (cmd_i.start) begin
      ptr_d   = '0;
      cnt_d   = '0;
      total_d = count_eff;
      order_d = itt_pkg::order_e'(walk_order_i);
      depth_d = itt_pkg::STK_W'(1);
    end else begin
      if (cmd_i.push_left || cmd_i.push_right) begin
        depth_d = depth_q + 1'b1;
      end else if (cmd_i.pop) begin
        depth_d = depth_q - 1'b1;
      end
    end
    if (cmd_i.emit) begin
      cnt_d = cnt_q + 1'b1;
    end
    // Hold the result until taken, refill from the read that just returned
    if (pend_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      order_q     <= itt_pkg::ORD_IN;
      depth_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      order_q     <= order_d;
      depth_q     <= depth_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stack frames and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      stk_q[0] <= '{idx: '0, ph: itt_pkg::PH_PRE};
    end else begin
      if (cmd_i.advance) begin
        stk_q[top_ptr].ph <= ph_next;
      end
      if (cmd_i.push_left) begin
        stk_q[depth_q] <= '{idx: left_idx[itt_pkg::IDX_W-1:0], ph: itt_pkg::PH_PRE};
      end else if (cmd_i.push_right) begin
        stk_q[depth_q] <= '{idx: right_idx[itt_pkg::IDX_W-1:0], ph: itt_pkg::PH_PRE};
      end
    end
    if (cmd_i.emit) begin
      pend_pos_q  <= cnt_q[itt_pkg::POS_W-1:0];
      pend_last_q <= (itt_pkg::CNT_W'(cnt_q + 1'b1) == total_q);
    end
    if (pend_q) begin
      out_value_q <= rdata;
      out_pos_q   <= pend_pos_q;
      out_last_q  <= pend_last_q;
    end
  end

  assign sts_o.slot_free  = !pend_q && (!out_valid_q || out_ready_i);
  assign sts_o.top_ph     = top.ph;
  assign sts_o.left_ok    = left_idx < {1'b0, total_q};
  assign sts_o.right_ok   = right_idx < {1'b0, total_q};
  assign sts_o.last_frame = (depth_q == itt_pkg::STK_W'(1));
  assign sts_o.order      = order_q;

  assign out_valid_o         = out_valid_q;
  assign node_value_o        = out_value_q;
  assign sequence_position_o = out_pos_q;
  assign last_in_walk_o      = out_last_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= STK_MAX)
    else $error("walk stack depth out of range");

  a_pend_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("store read returned while output register busy");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_left || cmd_i.push_right) |-> (depth_q < STK_MAX))
    else $error("push on full walk stack");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (cnt_q < total_q))
    else $error("more nodes emitted than the walk holds");

endmodule

/* rtl/implicit_tree_traversal_unit.sv */
// Load request: accepted back to back while idle.
// Walk request: visits N nodes (N = node_count, capped at 64); the stack sequencer takes
// one visit step per cycle while the output slot is free, three per node, plus one store
// read per result. Each result passes the registered store read, then the output register;
// the first comes soonest in pre-order, latest in post-order on a full seven-level tree. The
// output register holds results so the next request is accepted while the last is pending.
// Reset (async, active low) empties the stack, clears the load pointer and sets node_count to 1.
module implicit_tree_traversal_unit #(
  parameter int MAX_NODES = itt_pkg::MAX_NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  itt_in_if.sink                        in_req_i,
  itt_out_if.source                     out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itt_pkg::PADDR_W-1:0]   paddr,
  input  logic [itt_pkg::PDATA_W-1:0]   pwdata,
  output logic [itt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [itt_pkg::CNT_W-1:0] node_count_q;
  logic                      reg_hit;
  itt_pkg::cmd_t             cmd;
  itt_pkg::sts_t             sts;

  // Configuration register
  assign reg_hit = (paddr[itt_pkg::PADDR_W-1:2] == itt_pkg::REG_NODE_COUNT);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= itt_pkg::CNT_W'(1);
    end else if (psel && penable && pwrite && reg_hit) begin
      node_count_q <= pwdata[itt_pkg::CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? itt_pkg::PDATA_W'(node_count_q) : '0;

  itt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req_i.valid),
    .in_ready_o (in_req_i.ready),
    .in_kind_i  (in_req_i.kind),
    .in_order_i (in_req_i.walk_order),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itt_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .load_value_i        (in_req_i.load_value),
    .walk_order_i        (in_req_i.walk_order),
    .node_count_i        (node_count_q),
    .sts_o               (sts),
    .out_valid_o         (out_rsp_o.valid),
    .out_ready_i         (out_rsp_o.ready),
    .node_value_o        (out_rsp_o.node_value),
    .sequence_position_o (out_rsp_o.sequence_position),
    .last_in_walk_o      (out_rsp_o.last_in_walk)
  );

endmodule
